// ----- hdl/wfpj_pkg.sv -----
// Shared types, constants and helpers for the world-to-frame point transform.
package wfpj_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned IN_W         = 144;
  localparam int unsigned OUT_W        = 384;
  localparam int unsigned ANG_W        = 34;
  localparam int unsigned DIFF_W       = 33;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0]      QUARTER_POS = 16'sd16384;
  localparam logic signed [15:0]      QUARTER_NEG = -16'sd16384;

  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic                     vld;
    logic                     flip;
    logic signed [ANG_W-1:0]  x;
    logic signed [ANG_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cord_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/wfpj_cordic_cell.sv -----
// One rotation-mode CORDIC iteration with the point offsets carried alongside.
module wfpj_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  wfpj_pkg::cord_t   cin,
  output wfpj_pkg::cord_t   cout
);

  logic signed [wfpj_pkg::ANG_W-1:0] x_sh;
  logic signed [wfpj_pkg::ANG_W-1:0] y_sh;
  logic signed [wfpj_pkg::ANG_W-1:0] at;
  wfpj_pkg::cord_t                   cout_next;

  assign x_sh = $signed(cin.x) >>> STEP;
  assign y_sh = $signed(cin.y) >>> STEP;
  assign at   = $signed({2'b00, wfpj_pkg::ATAN_TURN32[STEP]});

  always_comb begin
    cout_next = cin;
    cout_next.vld = cin.vld && !rst;
    if (!cin.z[wfpj_pkg::ANG_W-1]) begin
      cout_next.x = $signed(cin.x) - y_sh;
      cout_next.y = $signed(cin.y) + x_sh;
      cout_next.z = $signed(cin.z) - at;
    end else begin
      cout_next.x = $signed(cin.x) + y_sh;
      cout_next.y = $signed(cin.y) - x_sh;
      cout_next.z = $signed(cin.z) + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en || rst) begin
      cout <= cout_next;
    end
  end

endmodule

// ----- hdl/wfpj_mac.sv -----
// Trig rounding, the four rotation products, and rounding/saturation of the results.
module wfpj_mac #(
  parameter int unsigned POS_FRAC_BITS  = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  wfpj_pkg::cord_t             cin,
  output logic                        res_vld,
  output logic [wfpj_pkg::OUT_W-1:0]  res_data
);

  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW  = wfpj_pkg::DIFF_W + TW;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned QW  = 40;
  localparam int unsigned RSH = 30 - TRIG_FRAC_BITS;

  localparam logic signed [wfpj_pkg::ANG_W-1:0] T_HALF = 
    wfpj_pkg::ANG_W'(1) <<< (RSH - 1);
  localparam logic signed [wfpj_pkg::ANG_W-1:0] T_LIM = 
    wfpj_pkg::ANG_W'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] S_HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

  logic signed [wfpj_pkg::ANG_W-1:0] xr;
  logic signed [wfpj_pkg::ANG_W-1:0] yr;
  logic signed [wfpj_pkg::ANG_W-1:0] xc;
  logic signed [wfpj_pkg::ANG_W-1:0] yc;
  logic signed [TW-1:0]              c_next;
  logic signed [TW-1:0]              s_next;

  logic                              a_vld;
  logic signed [TW-1:0]              a_c;
  logic signed [TW-1:0]              a_s;
  logic signed [wfpj_pkg::DIFF_W-1:0] a_dx;
  logic signed [wfpj_pkg::DIFF_W-1:0] a_dy;

  logic                              b_vld;
  logic signed [TW-1:0]              b_c;
  logic signed [TW-1:0]              b_s;
  logic signed [PW-1:0]              b_cdx;
  logic signed [PW-1:0]              b_sdx;
  logic signed [PW-1:0]              b_cdy;
  logic signed [PW-1:0]              b_sdy;

  logic signed [SW-1:0]              sum_lx;
  logic signed [SW-1:0]              sum_ly;
  logic signed [SW-1:0]              sum_nlx;
  logic signed [SW-1:0]              rnd_lx;
  logic signed [SW-1:0]              rnd_ly;
  logic signed [SW-1:0]              rnd_nlx;
  logic signed [QW-1:0]              cp;
  logic signed [QW-1:0]              sp;
  logic [31:0]                       o_lx;
  logic [31:0]                       o_ly;
  logic [31:0]                       o_nlx;
  logic [31:0]                       o_cp;
  logic [31:0]                       o_sp;
  logic [31:0]                       o_ncp;
  logic [31:0]                       o_nsp;

  // Q30 to Q.T, round half up, clamp to unit, undo the half-turn fold
  assign xr = ($signed(cin.x) + T_HALF) >>> RSH;
  assign yr = ($signed(cin.y) + T_HALF) >>> RSH;

  always_comb begin
    xc = xr;
    yc = yr;
    if (xr > T_LIM) xc = T_LIM;
    if (xr < -T_LIM) xc = -T_LIM;
    if (yr > T_LIM) yc = T_LIM;
    if (yr < -T_LIM) yc = -T_LIM;
    c_next = cin.flip ? -xc[TW-1:0] : xc[TW-1:0];
    s_next = cin.flip ? -yc[TW-1:0] : yc[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= cin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c   <= c_next;
      a_s   <= s_next;
      a_dx  <= cin.dx;
      a_dy  <= cin.dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_c   <= a_c;
      b_s   <= a_s;
      b_cdx <= a_c * a_dx;
      b_sdx <= a_s * a_dx;
      b_cdy <= a_c * a_dy;
      b_sdy <= a_s * a_dy;
    end
  end

  assign sum_lx  = SW'(b_cdx) + SW'(b_sdy);
  assign sum_ly  = SW'(b_cdy) - SW'(b_sdx);
  assign sum_nlx = -SW'(b_cdx) - SW'(b_sdy);
  assign rnd_lx  = (sum_lx + S_HALF) >>> TRIG_FRAC_BITS;
  assign rnd_ly  = (sum_ly + S_HALF) >>> TRIG_FRAC_BITS;
  assign rnd_nlx = (sum_nlx + S_HALF) >>> TRIG_FRAC_BITS;

  generate
    if (POS_FRAC_BITS >= TRIG_FRAC_BITS) begin : g_up
      assign cp = QW'(b_c) <<< (POS_FRAC_BITS - TRIG_FRAC_BITS);
      assign sp = QW'(b_s) <<< (POS_FRAC_BITS - TRIG_FRAC_BITS);
    end else begin : g_down
      localparam int unsigned DSH = TRIG_FRAC_BITS - POS_FRAC_BITS;
      localparam logic signed [QW-1:0] D_HALF = QW'(1) <<< (DSH - 1);
      assign cp = (QW'(b_c) + D_HALF) >>> DSH;
      assign sp = (QW'(b_s) + D_HALF) >>> DSH;
    end
  endgenerate

  assign o_lx  = wfpj_pkg::sat32(64'(rnd_lx));
  assign o_ly  = wfpj_pkg::sat32(64'(rnd_ly));
  assign o_nlx = wfpj_pkg::sat32(64'(rnd_nlx));
  assign o_cp  = wfpj_pkg::sat32(64'(cp));
  assign o_sp  = wfpj_pkg::sat32(64'(sp));
  assign o_ncp = wfpj_pkg::sat32(-64'(cp));
  assign o_nsp = wfpj_pkg::sat32(-64'(sp));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= {o_cp, o_nsp, o_sp, o_cp, o_nlx, o_ncp, o_sp,
                   o_ly, o_nsp, o_ncp, o_ly, o_lx};
    end
  end

endmodule

// ----- hdl/wfpj_skid.sv -----
// Two-word output buffer that parts the pipeline from the downstream handshake.
module wfpj_skid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [wfpj_pkg::OUT_W-1:0]  din,
  output logic                        full,
  output logic                        tvalid,
  input  logic                        tready,
  output logic [wfpj_pkg::OUT_W-1:0]  tdata
);

  logic [wfpj_pkg::OUT_W-1:0] mem [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 cnt;
  logic                       pop;

  assign pop    = tvalid && tready;
  assign tvalid = (cnt != 2'd0);
  assign full   = (cnt == 2'd2);
  assign tdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/world_to_frame_point_jacobian.sv -----
// Top level: SE(2) world-to-frame point transform with pose and point Jacobians.
//
//  channel   dir  width  contents
//  s_axis    in   144    pose and world point, one word per point
//  m_axis    out  384    local point and ten Jacobian entries
//
// One word per cycle sustained while m_tready keeps the output buffer from filling;
// stages: input register, 30 CORDIC cells, 3 multiply/round stages, output buffer.
// Synchronous active-high reset clears all valid flags and the buffer.
// The whole pipeline holds while the two-word output buffer is full.
module world_to_frame_point_jacobian #(
  parameter int unsigned POS_FRAC_BITS  = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pose_x, pose_y, pose_heading, world_px, world_py
  input  logic [wfpj_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // local_x, local_y, dlx_dpose_x, dlx_dpose_y, dlx_dheading, dly_dpose_x,
  // dly_dpose_y, dly_dheading, dlx_dpoint_x, dlx_dpoint_y, dly_dpoint_x,
  // dly_dpoint_y
  output logic [wfpj_pkg::OUT_W-1:0]  m_tdata
);

  logic                              en;
  logic                              full;
  logic signed [31:0]                pose_x;
  logic signed [31:0]                pose_y;
  logic signed [15:0]                pose_heading;
  logic signed [31:0]                world_px;
  logic signed [31:0]                world_py;
  logic                              flip;
  logic [15:0]                       ang;
  wfpj_pkg::cord_t                   chain [wfpj_pkg::CORDIC_STEPS+1];
  logic                              res_vld;
  logic [wfpj_pkg::OUT_W-1:0]        res_data;

  assign en       = !full;
  assign s_tready = en;

  assign pose_x       = s_tdata[31:0];
  assign pose_y       = s_tdata[63:32];
  assign pose_heading = s_tdata[79:64];
  assign world_px     = s_tdata[111:80];
  assign world_py     = s_tdata[143:112];

  // fold into the right half-plane; results negated at the end
  assign flip = (pose_heading > wfpj_pkg::QUARTER_POS) ||
                (pose_heading < wfpj_pkg::QUARTER_NEG);
  assign ang  = flip ? {~pose_heading[15], pose_heading[14:0]} : pose_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0].vld <= s_tvalid;
    end
    if (en) begin
      chain[0].flip <= flip;
      chain[0].x    <= wfpj_pkg::CORDIC_GAIN;
      chain[0].y    <= '0;
      chain[0].z    <= {{2{ang[15]}}, ang, 16'h0000};
      chain[0].dx   <= {world_px[31], world_px} - {pose_x[31], pose_x};
      chain[0].dy   <= {world_py[31], world_py} - {pose_y[31], pose_y};
    end
  end

  generate
    for (genvar i = 0; i < wfpj_pkg::CORDIC_STEPS; i++) begin : g_cell
      wfpj_cordic_cell #(
        .STEP(i)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .cin  (chain[i]),
        .cout (chain[i+1])
      );
    end
  endgenerate

  wfpj_mac #(
    .POS_FRAC_BITS  (POS_FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cin      (chain[wfpj_pkg::CORDIC_STEPS]),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  wfpj_skid u_skid (
    .clk    (clk),
    .rst    (rst),
    .push   (en && res_vld),
    .din    (res_data),
    .full   (full),
    .tvalid (m_tvalid),
    .tready (m_tready),
    .tdata  (m_tdata)
  );

endmodule
